@@ hw/rtl/ssr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared constants, register indexes and sequencer states of the stick
// setpoint ramp.
// ----------------------------------------------------------------------------
package ssr_pkg;

  // Default build values
  localparam int unsigned STICK_FRAC_BITS_DEF = 14;
  localparam int unsigned TICK_RATE_HZ_DEF    = 100;

  // Setpoint limits
  localparam logic [8:0]  YAW_MAX    = 9'd360;
  localparam logic [17:0] ALT_MAX_MM = 18'd200000;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_INCREMENTAL_MODE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_STICK_ENABLE  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALT_STICK_ENABLE  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE          = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_RAMP_SPEED    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALT_RAMP_SPEED    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HOME_YAW    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ALTITUDE_MM = 4'd7;

  // Register reset values
  localparam logic [13:0] DEADZONE_RST       = 14'd1638;
  localparam logic [15:0] YAW_RAMP_SPEED_RST = 16'd11520;
  localparam logic [14:0] ALT_RAMP_SPEED_RST = 15'd5000;

  // Sequencer states
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RAMP  = 9'b000000010,
    S_DEN   = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_STEP  = 9'b000010000,
    S_WHOLE = 9'b000100000,
    S_ABS   = 9'b001000000,
    S_ABSAP = 9'b010000000,
    S_DONE  = 9'b100000000
  } ssr_state_e;

endpackage

@@ hw/rtl/stick_setpoint_ramp_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stick_setpoint_ramp_core
// Home yaw and return altitude setpoints driven by two stick channels, either
// mapped absolutely or ramped past a neutral deadzone, with save pulses.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                fields
//  in       sink       in_valid_i / in_stall_o   sticks_valid, yaw/alt sticks
//  out      source     out_valid_o / out_stall_i home_yaw_deg, altitude_mm,
//                                                yaw_save, alt_save
//  cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  One shared multiplier and a radix-2 restoring divider run under a one-hot
//  sequencer. An incremental channel past the deadzone runs STICK_FRAC_BITS
//  + 17 divide steps (31 at 14 fraction bits); yaw then applies one whole
//  degree per step and then leaves that loop. A centered stick skips the
//  divider, and absolute mapping multiplies, then applies, per channel.
//  The input stalls until its result is taken.
//  Reset is asynchronous and leaves no clearing pass; out_stall_i holds the
//  result, cfg is always ready.
// ----------------------------------------------------------------------------
module stick_setpoint_ramp_core
  import ssr_pkg::*;
#(
  parameter int unsigned STICK_FRAC_BITS = STICK_FRAC_BITS_DEF,
  parameter int unsigned TICK_RATE_HZ    = TICK_RATE_HZ_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input items
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  sticks_valid_i,
  input  logic signed [15:0]    yaw_stick_i,
  input  logic signed [15:0]    yaw_stick_dz_i,
  input  logic signed [15:0]    alt_stick_i,
  input  logic signed [15:0]    alt_stick_dz_i,
  // result items
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [8:0]            home_yaw_deg_o,
  output logic [17:0]           altitude_mm_o,
  output logic                  yaw_save_o,
  output logic                  alt_save_o,
  // configuration
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned F      = STICK_FRAC_BITS;
  localparam int unsigned NW     = F + 2;                 // clamped stick, signed
  localparam int unsigned MA_W   = 18;
  localparam int unsigned MB_W   = F + 2;
  localparam int unsigned P_W    = MA_W + MB_W;
  localparam int unsigned NUM_W  = F + 17;                // (|n|-dz) * speed
  localparam int unsigned TW     = $clog2(TICK_RATE_HZ + 1);
  localparam int unsigned DEN_W  = F + 1 + TW;
  localparam int unsigned CNT_W  = $clog2(NUM_W);
  localparam int unsigned QW     = 16;
  localparam int unsigned RW     = $clog2(256 * TICK_RATE_HZ + 65536) + 1;
  localparam int unsigned DZ_MAX = (95 * (1 << F)) / 100;

  localparam logic [F:0]              STICK_ONE = (F + 1)'(1 << F);
  localparam logic signed [RW-1:0]    DEG_U     = RW'(256 * TICK_RATE_HZ);
  localparam logic signed [17:0]      LIM_HI    = 18'sd1 <<< F;
  localparam logic [CNT_W-1:0]        CNT_LAST  = CNT_W'(NUM_W - 1);

  // configuration registers
  logic        mode_q, yaw_en_q, alt_en_q;
  logic [13:0] dz_cfg_q;
  logic [15:0] yaw_spd_q;
  logic [14:0] alt_spd_q;

  // sequencer and datapath
  ssr_state_e state_q, state_d;
  logic       chan_q, chan_d;
  logic signed [NW-1:0] n_yaw_q, n_yaw_d, n_alt_q, n_alt_d;
  logic [P_W-1:0]   prod_q, prod_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // architectural state
  logic [8:0]           yaw_sp_q, yaw_sp_d;
  logic [17:0]          alt_sp_q, alt_sp_d;
  logic signed [RW-1:0] yaw_rem_q, yaw_rem_d;
  logic                 yaw_uns_q, yaw_uns_d, alt_uns_q, alt_uns_d;
  logic                 ysave_q, ysave_d, asave_q, asave_d;

  logic                 in_acc, cfg_acc;
  logic [29:0]          dz_scaled;
  logic [F-1:0]         dz;
  logic signed [NW-1:0] cur_n;
  logic [NW-1:0]        cur_abs;
  logic [F:0]           mag;
  logic                 moving;
  logic [MA_W-1:0]      mul_a;
  logic [MB_W-1:0]      mul_b;
  logic [P_W-1:0]       mul_p;
  logic [DEN_W:0]       div_shift, div_diff;
  logic signed [RW-1:0] q_ext, yaw_step, rem_new;
  logic signed [19:0]   alt_sum, alt_q20;
  logic [17:0]          abs_v;

  function automatic logic signed [NW-1:0] clamp_stick(input logic signed [15:0] s);
    logic signed [17:0] v;
    v = 18'(s);
    if (v > LIM_HI) begin
      v = LIM_HI;
    end else if (v < -LIM_HI) begin
      v = -LIM_HI;
    end
    return v[NW-1:0];
  endfunction

  assign in_acc  = in_valid_i && !in_stall_o;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = (state_q == S_DONE);
  assign cfg_ready_o    = 1'b1;
  assign home_yaw_deg_o = yaw_sp_q;
  assign altitude_mm_o  = alt_sp_q;
  assign yaw_save_o     = ysave_q;
  assign alt_save_o     = asave_q;

  // deadzone rescaled to the stick format, capped at 0.95
  assign dz_scaled = {dz_cfg_q, 16'd0} >> (30 - F);
  assign dz = (dz_scaled > 30'(DZ_MAX)) ? F'(DZ_MAX) : dz_scaled[F-1:0];

  assign cur_n   = chan_q ? n_alt_q : n_yaw_q;
  assign cur_abs = cur_n[NW-1] ? NW'(-cur_n) : NW'(cur_n);
  assign mag     = cur_abs[F:0];
  assign moving  = (mag > {1'b0, dz});

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_RAMP) begin
      mul_a = chan_q ? MA_W'(alt_spd_q) : MA_W'(yaw_spd_q);
      mul_b = MB_W'(mag - {1'b0, dz});
    end else if (state_q == S_DEN) begin
      mul_a = chan_q ? MA_W'(TICK_RATE_HZ) : MA_W'(1);
      mul_b = MB_W'(STICK_ONE - {1'b0, dz});
    end else if (state_q == S_ABS) begin
      mul_a = chan_q ? MA_W'(ALT_MAX_MM) : MA_W'(YAW_MAX);
      mul_b = MB_W'(cur_n + $signed({1'b0, STICK_ONE}));
    end
  end
  assign mul_p = P_W'(mul_a) * P_W'(mul_b);

  // divider step and step application
  assign div_shift = {rem_q, num_q[NUM_W-1]};
  assign div_diff  = div_shift - {1'b0, den_q};
  assign q_ext     = {{(RW-QW){1'b0}}, num_q[QW-1:0]};
  assign yaw_step  = cur_n[NW-1] ? -q_ext : q_ext;
  assign rem_new   = yaw_rem_q + yaw_step;
  assign alt_q20   = {4'd0, num_q[QW-1:0]};
  assign alt_sum   = cur_n[NW-1] ? ($signed({2'b00, alt_sp_q}) - alt_q20)
                                 : ($signed({2'b00, alt_sp_q}) + alt_q20);
  assign abs_v     = prod_q[F+1 +: 18];

  always_comb begin
    state_d   = state_q;
    chan_d    = chan_q;
    n_yaw_d   = n_yaw_q;
    n_alt_d   = n_alt_q;
    prod_d    = prod_q;
    den_d     = den_q;
    num_d     = num_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    yaw_sp_d  = yaw_sp_q;
    alt_sp_d  = alt_sp_q;
    yaw_rem_d = yaw_rem_q;
    yaw_uns_d = yaw_uns_q;
    alt_uns_d = alt_uns_q;
    ysave_d   = ysave_q;
    asave_d   = asave_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ysave_d = 1'b0;
          asave_d = 1'b0;
          n_yaw_d = clamp_stick(mode_q ? yaw_stick_i : yaw_stick_dz_i);
          n_alt_d = clamp_stick(mode_q ? alt_stick_i : alt_stick_dz_i);
          chan_d  = !yaw_en_q;
          if (!sticks_valid_i || (!yaw_en_q && !alt_en_q)) begin
            state_d = S_DONE;
          end else begin
            state_d = mode_q ? S_RAMP : S_ABS;
          end
        end
      end
      S_RAMP: begin
        if (moving) begin
          prod_d  = mul_p;
          state_d = S_DEN;
        end else begin
          if (!chan_q) begin
            yaw_rem_d = '0;
            if (yaw_uns_q) begin
              ysave_d   = 1'b1;
              yaw_uns_d = 1'b0;
            end
          end else if (alt_uns_q) begin
            asave_d   = 1'b1;
            alt_uns_d = 1'b0;
          end
          // hand over to the altitude channel or finish
          if (!chan_q && alt_en_q) begin
            chan_d = 1'b1;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DEN: begin
        den_d   = mul_p[DEN_W-1:0];
        num_d   = prod_q[NUM_W-1:0];
        rem_d   = '0;
        cnt_d   = CNT_LAST;
        state_d = S_DIV;
      end
      S_DIV: begin
        // quotient bits shift in at the bottom of num
        if (!div_diff[DEN_W]) begin
          rem_d = div_diff[DEN_W-1:0];
          num_d = {num_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_d = div_shift[DEN_W-1:0];
          num_d = {num_q[NUM_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (!chan_q) begin
          yaw_rem_d = rem_new;
          if (rem_new >= DEG_U || rem_new <= -DEG_U) begin
            state_d = S_WHOLE;
          end else if (alt_en_q) begin
            chan_d  = 1'b1;
            state_d = S_RAMP;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          alt_uns_d = 1'b1;
          if (alt_sum < 0) begin
            alt_sp_d = '0;
          end else if (alt_sum > $signed({2'b00, ALT_MAX_MM})) begin
            alt_sp_d = ALT_MAX_MM;
          end else begin
            alt_sp_d = alt_sum[17:0];
          end
          state_d = S_DONE;
        end
      end
      S_WHOLE: begin
        // move one whole degree per cycle, saturating at the limits
        if (yaw_rem_q >= DEG_U) begin
          yaw_rem_d = yaw_rem_q - DEG_U;
          yaw_uns_d = 1'b1;
          if (yaw_sp_q < YAW_MAX) begin
            yaw_sp_d = yaw_sp_q + 1'b1;
          end
        end else if (yaw_rem_q <= -DEG_U) begin
          yaw_rem_d = yaw_rem_q + DEG_U;
          yaw_uns_d = 1'b1;
          if (yaw_sp_q != '0) begin
            yaw_sp_d = yaw_sp_q - 1'b1;
          end
        end else if (alt_en_q) begin
          chan_d  = 1'b1;
          state_d = S_RAMP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_ABS: begin
        prod_d  = mul_p;
        state_d = S_ABSAP;
      end
      S_ABSAP: begin
        if (!chan_q) begin
          if (abs_v[8:0] != yaw_sp_q) begin
            yaw_sp_d = abs_v[8:0];
            ysave_d  = 1'b1;
          end
        end else if (abs_v != alt_sp_q) begin
          alt_sp_d = abs_v;
          asave_d  = 1'b1;
        end
        if (!chan_q && alt_en_q) begin
          chan_d  = 1'b1;
          state_d = S_ABS;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // start values load the setpoints, saturated
    if (cfg_acc && cfg_index_i == CFG_START_HOME_YAW) begin
      yaw_sp_d = (cfg_data_i[8:0] > YAW_MAX) ? YAW_MAX : cfg_data_i[8:0];
    end
    if (cfg_acc && cfg_index_i == CFG_START_ALTITUDE_MM) begin
      alt_sp_d = (cfg_data_i > ALT_MAX_MM) ? ALT_MAX_MM : cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      chan_q    <= 1'b0;
      yaw_sp_q  <= '0;
      alt_sp_q  <= '0;
      yaw_rem_q <= '0;
      yaw_uns_q <= 1'b0;
      alt_uns_q <= 1'b0;
      ysave_q   <= 1'b0;
      asave_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      chan_q    <= chan_d;
      yaw_sp_q  <= yaw_sp_d;
      alt_sp_q  <= alt_sp_d;
      yaw_rem_q <= yaw_rem_d;
      yaw_uns_q <= yaw_uns_d;
      alt_uns_q <= alt_uns_d;
      ysave_q   <= ysave_d;
      asave_q   <= asave_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_yaw_q <= n_yaw_d;
    n_alt_q <= n_alt_d;
    prod_q  <= prod_d;
    den_q   <= den_d;
    num_q   <= num_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      yaw_en_q  <= 1'b0;
      alt_en_q  <= 1'b0;
      dz_cfg_q  <= DEADZONE_RST;
      yaw_spd_q <= YAW_RAMP_SPEED_RST;
      alt_spd_q <= ALT_RAMP_SPEED_RST;
    end else if (cfg_acc) begin
      case (cfg_index_i)
        CFG_INCREMENTAL_MODE: mode_q    <= cfg_data_i[0];
        CFG_YAW_STICK_ENABLE: yaw_en_q  <= cfg_data_i[0];
        CFG_ALT_STICK_ENABLE: alt_en_q  <= cfg_data_i[0];
        CFG_DEADZONE:         dz_cfg_q  <= cfg_data_i[13:0];
        CFG_YAW_RAMP_SPEED:   yaw_spd_q <= cfg_data_i[15:0];
        CFG_ALT_RAMP_SPEED:   alt_spd_q <= cfg_data_i[14:0];
        default: begin
        end
      endcase
    end
  end

  // assertions
  a_setpoint_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (yaw_sp_q <= YAW_MAX) && (alt_sp_q <= ALT_MAX_MM))
    else $error("setpoint out of range");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (den_q != '0))
    else $error("divider started with zero divisor");

  a_rem_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (yaw_rem_q < DEG_U && yaw_rem_q > -DEG_U))
    else $error("yaw remainder holds a whole degree between ticks");

  a_save_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_acc) |=> (!ysave_q && !asave_q))
    else $error("save pulse not cleared at start of transaction");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (state_q == S_DONE))
    else $error("stalled result dropped");

endmodule
